// ----- src/cbcs_pkg.sv -----
`timescale 1ns / 1ps

package cbcs_pkg;

  localparam int unsigned WGT_WIDTH = 17;
  localparam int unsigned RES_WIDTH = 6;
  localparam int unsigned CNT_WIDTH = 3;
  localparam int unsigned NUM_POINTS = 4;

  localparam logic [WGT_WIDTH-1:0] ONE_Q16 = 17'h10000;
  localparam logic [RES_WIDTH-1:0] RES_RESET = 6'd16;
  localparam logic [1:0] REG_RESOLUTION = 2'd0;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_T_INIT,
    OP_T_NEXT,
    OP_U,
    OP_UU,
    OP_TT,
    OP_W0,
    OP_W1,
    OP_W2,
    OP_W3,
    OP_BLEND
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] k;
    logic [1:0] c;
  } cmd_t;

endpackage

// ----- src/cubic_bezier_curve_sampler.sv -----
`timescale 1ns / 1ps

// Cubic Bezier sampler: control points (x, y, z, signed Q16.16) stream in one
// per transaction, one cycle each; the first four of a list are kept. The
// transaction with tlast ends the list and, with four points present and a
// nonzero resolution, starts a run of resolution+1 samples. A run first
// computes 65536/resolution bit-serially, then for each sample forms u = 1 - t,
// then u*u, t*t and the four Bernstein weights on a shared 17x17 multiplier,
// the weighted sums on a shared weight-by-coordinate multiplier, finishes the
// last sum, holds the sample in the output register until the sink takes it
// and then advances t; the last sample skips the advance. No input is taken
// while a run is in progress.
module cubic_bezier_curve_sampler #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // tdata: coord_x, coord_y, coord_z (zero padded to bytes)
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic                 s_axis_tlast,
  // tdata: out_x, out_y, out_z, sample_index (zero padded to bytes)
  output logic [((3*COORD_WIDTH+6+7)/8)*8-1:0] m_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic                 m_axis_tlast,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int unsigned OUT_W = ((3*COORD_WIDTH+6+7)/8)*8;

  logic [cbcs_pkg::RES_WIDTH-1:0] res_q;
  logic [cbcs_pkg::RES_WIDTH-1:0] sample_idx;
  cbcs_pkg::cmd_t cmd;
  logic signed [COORD_WIDTH-1:0] out_x, out_y, out_z;
  logic reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[3:2] == cbcs_pkg::REG_RESOLUTION);
  assign prdata  = reg_hit ? 32'(res_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= cbcs_pkg::RES_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      res_q <= pwdata[cbcs_pkg::RES_WIDTH-1:0];
    end
  end

  cbcs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_i        (res_q),
    .in_valid_i   (s_axis_tvalid),
    .in_last_i    (s_axis_tlast),
    .in_ready_o   (s_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_last_o   (m_axis_tlast),
    .sample_idx_o (sample_idx),
    .cmd_o        (cmd)
  );

  cbcs_dp #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .res_i     (res_q),
    .coord_x_i (s_axis_tdata[COORD_WIDTH-1:0]),
    .coord_y_i (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .coord_z_i (s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
    .out_x_o   (out_x),
    .out_y_o   (out_y),
    .out_z_o   (out_z)
  );

  assign m_axis_tdata = OUT_W'({sample_idx, out_z, out_y, out_x});

endmodule

// ----- src/cbcs_dp.sv -----
`timescale 1ns / 1ps

module cbcs_dp #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  cbcs_pkg::cmd_t                       cmd_i,
  input  logic [cbcs_pkg::RES_WIDTH-1:0]       res_i,
  input  logic signed [COORD_WIDTH-1:0]        coord_x_i,
  input  logic signed [COORD_WIDTH-1:0]        coord_y_i,
  input  logic signed [COORD_WIDTH-1:0]        coord_z_i,
  output logic signed [COORD_WIDTH-1:0]        out_x_o,
  output logic signed [COORD_WIDTH-1:0]        out_y_o,
  output logic signed [COORD_WIDTH-1:0]        out_z_o
);

  localparam int unsigned WW = cbcs_pkg::WGT_WIDTH;
  localparam int unsigned RW = cbcs_pkg::RES_WIDTH;
  localparam int unsigned PW = COORD_WIDTH + 18;

  logic signed [COORD_WIDTH-1:0] pt_q [cbcs_pkg::NUM_POINTS][3];
  logic [WW-1:0] w_q [cbcs_pkg::NUM_POINTS];

  // divider for 65536 / resolution
  logic [RW-1:0] div_r_q;
  logic [WW-1:0] div_q_q;
  logic [WW-1:0] div_n_q;
  logic [RW:0]   div_rs;
  logic          div_ge;

  // curve parameter and weight scratch
  logic [WW-1:0] t_q, u_q, uu_q, tt_q;
  logic [RW-1:0] tr_q;
  logic [RW:0]   tr_sum;
  logic          tr_ge;

  logic [WW-1:0]   ma, mb;
  logic [2*WW-1:0] wprod;
  logic [2*WW+1:0] wprod3;
  logic [WW-1:0]   wres;

  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] acc_q;
  logic signed [PW-1:0] sum;
  logic                 bvalid_q;
  logic [1:0]           bk_q, bc_q;

  assign div_rs = {div_r_q, div_n_q[WW-1]};
  assign div_ge = div_rs >= {1'b0, res_i};
  assign tr_sum = {1'b0, tr_q} + {1'b0, div_r_q};
  assign tr_ge  = tr_sum >= {1'b0, res_i};

  always_comb begin
    unique case (cmd_i.op)
      cbcs_pkg::OP_TT: begin
        ma = t_q;
        mb = t_q;
      end
      cbcs_pkg::OP_W0: begin
        ma = uu_q;
        mb = u_q;
      end
      cbcs_pkg::OP_W1: begin
        ma = uu_q;
        mb = t_q;
      end
      cbcs_pkg::OP_W2: begin
        ma = u_q;
        mb = tt_q;
      end
      cbcs_pkg::OP_W3: begin
        ma = tt_q;
        mb = t_q;
      end
      default: begin
        ma = u_q;
        mb = u_q;
      end
    endcase
  end

  assign wprod  = ma * mb;
  assign wprod3 = {2'b00, wprod} + {1'b0, wprod, 1'b0};
  assign wres   = (cmd_i.op == cbcs_pkg::OP_W1 || cmd_i.op == cbcs_pkg::OP_W2)
                  ? wprod3[2*WW-2:WW-1] : wprod[2*WW-2:WW-1];

  assign sum = ((bk_q == 2'd0) ? PW'(0) : acc_q) + prod_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      cbcs_pkg::OP_LOAD: begin
        pt_q[cmd_i.k][0] <= coord_x_i;
        pt_q[cmd_i.k][1] <= coord_y_i;
        pt_q[cmd_i.k][2] <= coord_z_i;
      end
      cbcs_pkg::OP_DIV_INIT: begin
        div_r_q <= '0;
        div_q_q <= '0;
        div_n_q <= cbcs_pkg::ONE_Q16;
      end
      cbcs_pkg::OP_DIV_STEP: begin
        div_r_q <= div_ge ? RW'(div_rs - {1'b0, res_i}) : div_rs[RW-1:0];
        div_q_q <= {div_q_q[WW-2:0], div_ge};
        div_n_q <= {div_n_q[WW-2:0], 1'b0};
      end
      cbcs_pkg::OP_T_INIT: begin
        t_q  <= '0;
        tr_q <= '0;
      end
      cbcs_pkg::OP_T_NEXT: begin
        // carry the running remainder into the quotient
        if (tr_ge) begin
          t_q  <= t_q + div_q_q + WW'(1);
          tr_q <= RW'(tr_sum - {1'b0, res_i});
        end else begin
          t_q  <= t_q + div_q_q;
          tr_q <= tr_sum[RW-1:0];
        end
      end
      cbcs_pkg::OP_U:  u_q  <= cbcs_pkg::ONE_Q16 - t_q;
      cbcs_pkg::OP_UU: uu_q <= wres;
      cbcs_pkg::OP_TT: tt_q <= wres;
      cbcs_pkg::OP_W0: w_q[0] <= wres;
      cbcs_pkg::OP_W1: w_q[1] <= wres;
      cbcs_pkg::OP_W2: w_q[2] <= wres;
      cbcs_pkg::OP_W3: w_q[3] <= wres;
      cbcs_pkg::OP_BLEND: begin
        prod_q <= $signed({1'b0, w_q[cmd_i.k]}) * pt_q[cmd_i.k][cmd_i.c];
      end
      default: ;
    endcase
    bk_q <= cmd_i.k;
    bc_q <= cmd_i.c;
    if (bvalid_q) begin
      acc_q <= sum;
      if (bk_q == 2'd3) begin
        case (bc_q)
          2'd0:    out_x_o <= sum[COORD_WIDTH+15:16];
          2'd1:    out_y_o <= sum[COORD_WIDTH+15:16];
          default: out_z_o <= sum[COORD_WIDTH+15:16];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvalid_q <= 1'b0;
    end else begin
      bvalid_q <= (cmd_i.op == cbcs_pkg::OP_BLEND);
    end
  end

endmodule

// ----- src/cbcs_ctrl.sv -----
`timescale 1ns / 1ps

module cbcs_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [cbcs_pkg::RES_WIDTH-1:0]  res_i,
  input  logic                            in_valid_i,
  input  logic                            in_last_i,
  output logic                            in_ready_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            out_last_o,
  output logic [cbcs_pkg::RES_WIDTH-1:0]  sample_idx_o,
  output cbcs_pkg::cmd_t                  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DINIT,
    ST_DIV,
    ST_TINIT,
    ST_WGT,
    ST_BLEND,
    ST_DRAIN,
    ST_EMIT,
    ST_TNEXT
  } state_e;

  localparam logic [4:0] DIV_LAST   = 5'd16;
  localparam logic [4:0] WGT_LAST   = 5'd6;
  localparam logic [4:0] BLEND_LAST = 5'd11;

  state_e state_q;
  logic [4:0] step_q;
  logic [cbcs_pkg::CNT_WIDTH-1:0] cnt_q, cnt_inc;
  logic [cbcs_pkg::RES_WIDTH-1:0] idx_q;
  logic accept, out_hs;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign accept       = in_valid_i && in_ready_o;
  assign out_valid_o  = (state_q == ST_EMIT);
  assign out_last_o   = (idx_q == res_i);
  assign out_hs       = out_valid_o && out_ready_i;
  assign sample_idx_o = idx_q;
  assign cnt_inc      = (cnt_q < 3'd4) ? cnt_q + 3'd1 : cnt_q;

  always_comb begin
    cmd_o.op = cbcs_pkg::OP_NOP;
    cmd_o.k  = step_q[1:0];
    cmd_o.c  = step_q[3:2];
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.k = cnt_q[1:0];
        if (accept && cnt_q < 3'd4) begin
          cmd_o.op = cbcs_pkg::OP_LOAD;
        end
      end
      ST_DINIT: cmd_o.op = cbcs_pkg::OP_DIV_INIT;
      ST_DIV:   cmd_o.op = cbcs_pkg::OP_DIV_STEP;
      ST_TINIT: cmd_o.op = cbcs_pkg::OP_T_INIT;
      ST_TNEXT: cmd_o.op = cbcs_pkg::OP_T_NEXT;
      ST_BLEND: cmd_o.op = cbcs_pkg::OP_BLEND;
      ST_WGT: begin
        unique case (step_q[2:0])
          3'd0:    cmd_o.op = cbcs_pkg::OP_U;
          3'd1:    cmd_o.op = cbcs_pkg::OP_UU;
          3'd2:    cmd_o.op = cbcs_pkg::OP_TT;
          3'd3:    cmd_o.op = cbcs_pkg::OP_W0;
          3'd4:    cmd_o.op = cbcs_pkg::OP_W1;
          3'd5:    cmd_o.op = cbcs_pkg::OP_W2;
          default: cmd_o.op = cbcs_pkg::OP_W3;
        endcase
      end
      default: cmd_o.op = cbcs_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (in_last_i) begin
              cnt_q <= '0;
              idx_q <= '0;
              if (cnt_inc == 3'd4 && res_i != '0) begin
                state_q <= ST_DINIT;
              end
            end else begin
              cnt_q <= cnt_inc;
            end
          end
        end
        ST_DINIT: begin
          step_q  <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          step_q <= step_q + 5'd1;
          if (step_q == DIV_LAST) begin
            state_q <= ST_TINIT;
          end
        end
        ST_TINIT: begin
          step_q  <= '0;
          state_q <= ST_WGT;
        end
        ST_WGT: begin
          if (step_q == WGT_LAST) begin
            step_q  <= '0;
            state_q <= ST_BLEND;
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        ST_BLEND: begin
          step_q <= step_q + 5'd1;
          if (step_q == BLEND_LAST) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: state_q <= ST_EMIT;
        ST_EMIT: begin
          if (out_ready_i) begin
            if (out_last_o) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q + 6'd1;
              state_q <= ST_TNEXT;
            end
          end
        end
        ST_TNEXT: begin
          step_q  <= '0;
          state_q <= ST_WGT;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(idx_q))
    else $error("sample dropped before transaction");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && in_ready_o))
    else $error("input taken during sample output");
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_hs && !out_last_o |=> idx_q == $past(idx_q) + 6'd1)
    else $error("sample index skipped");
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> idx_q <= res_i)
    else $error("sample index beyond resolution");
`endif

endmodule
